FILE: rtl/aac_asc_pkg.sv
// ----------------------------------------------------------------------------
// aac_asc_pkg
// Types, field codes, phase table and lookup functions of the
// AudioSpecificConfig parser.
// ----------------------------------------------------------------------------
package aac_asc_pkg;

  localparam int NREC = 5;   // records one parsed bit can raise

  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_EMIT  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUP   = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_BADFREQ = 2'd3;

  localparam logic [10:0] SYNC_SBR = 11'h2b7;
  localparam logic [10:0] SYNC_PS  = 11'h548;
  localparam logic [5:0]  AOT_ESC  = 6'd31;
  localparam logic [3:0]  SFI_ESC  = 4'h0f;
  localparam logic [5:0]  AOT_SBR  = 6'd5;
  localparam logic [5:0]  AOT_PS   = 6'd29;

  localparam logic [5:0] FID_AOT      = 6'd0;
  localparam logic [5:0] FID_SFI      = 6'd1;
  localparam logic [5:0] FID_SF       = 6'd2;
  localparam logic [5:0] FID_CH       = 6'd3;
  localparam logic [5:0] FID_SBR      = 6'd4;
  localparam logic [5:0] FID_PS       = 6'd5;
  localparam logic [5:0] FID_XAOT     = 6'd6;
  localparam logic [5:0] FID_XSFI     = 6'd7;
  localparam logic [5:0] FID_XSF      = 6'd8;
  localparam logic [5:0] FID_XCH      = 6'd9;
  localparam logic [5:0] FID_FLF      = 6'd10;
  localparam logic [5:0] FID_DOC      = 6'd11;
  localparam logic [5:0] FID_CCD      = 6'd12;
  localparam logic [5:0] FID_EXTF     = 6'd13;
  localparam logic [5:0] FID_LAYER    = 6'd14;
  localparam logic [5:0] FID_NSF      = 6'd15;
  localparam logic [5:0] FID_LLEN     = 6'd16;
  localparam logic [5:0] FID_RES1     = 6'd17;
  localparam logic [5:0] FID_RES2     = 6'd18;
  localparam logic [5:0] FID_RES3     = 6'd19;
  localparam logic [5:0] FID_EXT3     = 6'd20;
  localparam logic [5:0] FID_EP       = 6'd21;
  localparam logic [5:0] FID_SYNC     = 6'd23;
  localparam logic [5:0] FID_TAG      = 6'd24;
  localparam logic [5:0] FID_PROFILE  = 6'd25;
  localparam logic [5:0] FID_PSFI     = 6'd26;
  localparam logic [5:0] FID_NFRONT   = 6'd27;
  localparam logic [5:0] FID_MONO     = 6'd33;
  localparam logic [5:0] FID_MONO_N   = 6'd34;
  localparam logic [5:0] FID_STEREO   = 6'd35;
  localparam logic [5:0] FID_STEREO_N = 6'd36;
  localparam logic [5:0] FID_MATRIX   = 6'd37;
  localparam logic [5:0] FID_MIDX     = 6'd38;
  localparam logic [5:0] FID_PSEUDO   = 6'd39;
  localparam logic [5:0] FID_F_CPE    = 6'd40;
  localparam logic [5:0] FID_F_TAG    = 6'd41;
  localparam logic [5:0] FID_S_CPE    = 6'd42;
  localparam logic [5:0] FID_S_TAG    = 6'd43;
  localparam logic [5:0] FID_B_CPE    = 6'd44;
  localparam logic [5:0] FID_B_TAG    = 6'd45;
  localparam logic [5:0] FID_L_TAG    = 6'd46;
  localparam logic [5:0] FID_A_TAG    = 6'd47;
  localparam logic [5:0] FID_C_IND    = 6'd48;
  localparam logic [5:0] FID_C_TAG    = 6'd49;
  localparam logic [5:0] FID_CCOUNT   = 6'd50;
  localparam logic [5:0] FID_CBYTE    = 6'd51;
  localparam logic [5:0] FID_SUMMARY  = 6'd63;

  typedef enum logic [5:0] {
    PH_AOT, PH_AOT_ESC, PH_SFI, PH_SF_X, PH_CH, PH_XSFI, PH_XSF_X, PH_AOT2,
    PH_AOT2_ESC, PH_XCH_I, PH_FLF, PH_DOC, PH_CCD, PH_EXTF, PH_TAG, PH_POT,
    PH_PSFI, PH_NF, PH_NS, PH_NB, PH_NL, PH_NA, PH_NC, PH_MONO, PH_MONO_N,
    PH_STEREO, PH_STEREO_N, PH_MATRIX, PH_MIDX, PH_PSEUDO, PH_F_CPE, PH_F_TAG,
    PH_S_CPE, PH_S_TAG, PH_B_CPE, PH_B_TAG, PH_L_TAG, PH_A_TAG, PH_C_IND,
    PH_C_TAG, PH_ALIGN, PH_CCOUNT, PH_CBYTE, PH_LAYER, PH_NSF, PH_LLEN,
    PH_RES1, PH_RES2, PH_RES3, PH_EXT3, PH_EP, PH_SYNC, PH_XAOT, PH_XAOT_ESC,
    PH_SBR, PH_XSFI2, PH_XSF2_X, PH_SYNC2, PH_PS, PH_XCH, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    J_NONE, J_AFTER_AOT2, J_DISPATCH, J_GA_TAIL, J_GA_EXT, J_GA_RES,
    J_EP_CHECK, J_EXT_CHECK, J_AFTER_XSF2, J_LIST, J_FINISH
  } jump_t;

  typedef struct packed {
    logic [5:0]  field_id;
    logic [7:0]  element_index;
    logic [23:0] field_value;
    logic [1:0]  status;
    logic        last_result;
  } rec_t;

  typedef struct packed {
    logic                 push;
    logic [2:0]           cnt;
    rec_t [NREC-1:0]      recs;
  } batch_t;

  typedef struct packed {
    logic [9:0] total_bytes;
    logic       emit_comment_bytes;
  } cfg_t;

  function automatic logic [4:0] width_of(phase_t p);
    case (p)
      PH_FLF, PH_DOC, PH_EXTF, PH_MONO, PH_STEREO, PH_MATRIX, PH_PSEUDO,
      PH_F_CPE, PH_S_CPE, PH_B_CPE, PH_C_IND, PH_RES1, PH_RES2, PH_RES3,
      PH_EXT3, PH_SBR, PH_PS:                               return 5'd1;
      PH_POT, PH_NL, PH_MIDX, PH_EP:                       return 5'd2;
      PH_NA, PH_LAYER:                                     return 5'd3;
      PH_SFI, PH_CH, PH_XSFI, PH_XCH_I, PH_TAG, PH_PSFI, PH_NF, PH_NS,
      PH_NB, PH_NC, PH_MONO_N, PH_STEREO_N, PH_F_TAG, PH_S_TAG, PH_B_TAG,
      PH_L_TAG, PH_A_TAG, PH_C_TAG, PH_XSFI2, PH_XCH:      return 5'd4;
      PH_AOT, PH_AOT2, PH_NSF, PH_XAOT:                    return 5'd5;
      PH_AOT_ESC, PH_AOT2_ESC, PH_XAOT_ESC:                return 5'd6;
      PH_CCOUNT, PH_CBYTE:                                 return 5'd8;
      PH_LLEN, PH_SYNC, PH_SYNC2:                          return 5'd11;
      PH_CCD:                                              return 5'd14;
      PH_SF_X, PH_XSF_X, PH_XSF2_X:                        return 5'd24;
      default:                                             return 5'd0;
    endcase
  endfunction

  function automatic logic [23:0] freq_of(logic [3:0] idx);
    case (idx)
      4'd0:    return 24'd96000;
      4'd1:    return 24'd88200;
      4'd2:    return 24'd64000;
      4'd3:    return 24'd48000;
      4'd4:    return 24'd44100;
      4'd5:    return 24'd32000;
      4'd6:    return 24'd24000;
      4'd7:    return 24'd22050;
      4'd8:    return 24'd16000;
      4'd9:    return 24'd12000;
      4'd10:   return 24'd11025;
      4'd11:   return 24'd8000;
      4'd12:   return 24'd7350;
      default: return 24'd0;
    endcase
  endfunction

  function automatic phase_t list_first(logic [2:0] k);
    case (k)
      3'd0:    return PH_F_CPE;
      3'd1:    return PH_S_CPE;
      3'd2:    return PH_B_CPE;
      3'd3:    return PH_L_TAG;
      3'd4:    return PH_A_TAG;
      default: return PH_C_IND;
    endcase
  endfunction

  function automatic logic is_ga(logic [5:0] t);
    return t inside {[6'd1:6'd4], 6'd6, 6'd7, [6'd17:6'd23]};
  endfunction

  function automatic logic is_unsup(logic [5:0] t);
    return t inside {6'd8, 6'd9, [6'd12:6'd16], [6'd24:6'd28], 6'd30, [6'd32:6'd41]};
  endfunction

  function automatic logic has_ep(logic [5:0] t);
    return t inside {6'd17, [6'd19:6'd27], 6'd39};
  endfunction

endpackage

FILE: rtl/aac_asc_in_if.sv
// ----------------------------------------------------------------------------
// aac_asc_in_if
// Byte channel into the parser: one blob byte per beat.
// ----------------------------------------------------------------------------
interface aac_asc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

FILE: rtl/aac_asc_out_if.sv
// ----------------------------------------------------------------------------
// aac_asc_out_if
// Result channel of the parser: one parsed field record per beat.
// ----------------------------------------------------------------------------
interface aac_asc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  field_id;
  logic [7:0]  element_index;
  logic [23:0] field_value;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output field_id, output element_index,
                  output field_value, output status, output last_result, input ready);
  modport sink   (input valid, input field_id, input element_index,
                  input field_value, input status, input last_result, output ready);
endinterface

FILE: rtl/aac_audio_specific_config_parser_unit.sv
// ----------------------------------------------------------------------------
// aac_audio_specific_config_parser_unit
// Parses AudioSpecificConfig blobs into records, one bit per unstalled cycle.
// ----------------------------------------------------------------------------
// A byte is taken only while the core is idle; its 8 bits then go through the
// field shifter at one bit per cycle while the record queue is empty. A bit's
// records are registered in the queue, then in its output stage, and leave one
// beat per cycle while the receiver is ready; the queue holds the bit shifter.
// Reset (rst_n low, synchronous): parser waits for an object type, all
// counters clear, total_bytes = 2, emit_comment_bytes = 1.
module aac_audio_specific_config_parser_unit (
  input  logic          clk,
  input  logic          rst_n,
  aac_asc_in_if.sink    in_ch,
  aac_asc_out_if.source out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import aac_asc_pkg::*;

  cfg_t   cfg;
  batch_t core_batch;
  logic   q_empty;

  aac_asc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aac_asc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_ch     (in_ch),
    .q_empty_i (q_empty),
    .batch_o   (core_batch)
  );

  aac_asc_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .batch_i (core_batch),
    .empty_o (q_empty),
    .out_ch  (out_ch)
  );

  // a bit is only parsed once the previous records have all left the queue
  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    core_batch.push |-> q_empty)
    else $error("record batch pushed while queue busy");

  a_batch_fits: assert property (@(posedge clk) disable iff (!rst_n)
    core_batch.push |-> core_batch.cnt <= 3'(NREC))
    else $error("record batch overflows queue");

  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_result |->
      out_ch.field_id == FID_SUMMARY && out_ch.element_index == 8'd0)
    else $error("last beat is not a summary record");
endmodule

FILE: rtl/aac_asc_cfg.sv
// ----------------------------------------------------------------------------
// aac_asc_cfg
// APB register file: blob length and comment byte enable.
// ----------------------------------------------------------------------------
module aac_asc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output aac_asc_pkg::cfg_t  cfg_o
);
  import aac_asc_pkg::*;

  logic [9:0] total_r;
  logic       emit_r;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 10'd2;
      emit_r  <= 1'b1;
    end else if (wr) begin
      if (paddr[2] == REG_TOTAL) total_r <= pwdata[9:0];
      else                       emit_r  <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_EMIT) ? {31'd0, emit_r} : {22'd0, total_r};
  assign cfg_o  = '{total_bytes: total_r, emit_comment_bytes: emit_r};
endmodule

FILE: rtl/aac_asc_core.sv
// ----------------------------------------------------------------------------
// aac_asc_core
// Bit-serial field parser: shifts one blob bit per cycle, while the queue is
// empty, into the field register; runs the syntax sequencer when a field ends.
// ----------------------------------------------------------------------------
module aac_asc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aac_asc_pkg::cfg_t    cfg_i,
  aac_asc_in_if.sink           in_ch,
  input  logic                 q_empty_i,
  output aac_asc_pkg::batch_t  batch_o
);
  import aac_asc_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [5:0]  ot_r, ot_nxt;
  logic [5:0]  xot_r, xot_nxt;
  logic [3:0]  ch_r, ch_nxt;
  logic        bad_r, bad_nxt;
  logic        ext_r, ext_nxt;
  logic [3:0]  cnt_r [6];
  logic [3:0]  cnt_nxt [6];
  logic [7:0]  ec_r, ec_nxt;
  logic [12:0] bits_r, bits_nxt;
  logic [9:0]  seen_r, seen_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  bitcnt_r, bitcnt_nxt;
  logic        active_r, active_nxt;

  logic            in_acc, step;
  logic [23:0]     v;
  rec_t [NREC-1:0] recs;
  logic [2:0]      n;
  jump_t           jmp;
  logic            ent;
  phase_t          tgt;
  logic [1:0]      fin_st;
  logic [2:0]      lk;
  logic            found;
  logic [6:0]      esc7;
  logic [4:0]      alg_left;
  logic [13:0]     rem;
  logic            rem_ge16, rem_ge12;
  logic [2:0]      nt;

  function automatic rec_t mk_rec(logic [5:0] id, logic [7:0] idx, logic [23:0] val,
                                  logic bad);
    return '{field_id: id, element_index: idx, field_value: val,
             status: bad ? ST_BADFREQ : ST_OK, last_result: 1'b0};
  endfunction

  assign in_ch.ready = !active_r;
  assign in_acc      = in_ch.valid && !active_r;
  assign step        = active_r && q_empty_i;

  always_comb begin
    ph_nxt = ph_r;   shift_nxt = shift_r; left_nxt = left_r;
    ot_nxt = ot_r;   xot_nxt = xot_r;     ch_nxt = ch_r;
    bad_nxt = bad_r; ext_nxt = ext_r;     cnt_nxt = cnt_r;
    ec_nxt = ec_r;   bits_nxt = bits_r;   seen_nxt = seen_r;
    byte_nxt = byte_r; bitcnt_nxt = bitcnt_r; active_nxt = active_r;
    v = '0; recs = '0; n = '0; jmp = J_NONE; ent = 1'b0; tgt = ph_r;
    fin_st = ST_OK; lk = '0; found = 1'b0; esc7 = '0; nt = '0;
    alg_left = '0; rem = '0; rem_ge16 = 1'b0; rem_ge12 = 1'b0;

    if (in_acc) begin
      if (in_ch.frame_start) begin
        ph_nxt = PH_AOT; left_nxt = width_of(PH_AOT); shift_nxt = '0;
        ot_nxt = '0; xot_nxt = '0; ch_nxt = '0; bad_nxt = 1'b0; ext_nxt = 1'b0;
        for (int k = 0; k < 6; k++) cnt_nxt[k] = '0;
        ec_nxt = '0; bits_nxt = '0; seen_nxt = '0;
      end
      if (ph_nxt != PH_DONE) begin
        if (seen_nxt != 10'd1023) seen_nxt = seen_nxt + 10'd1;
        active_nxt = 1'b1;
        byte_nxt   = in_ch.data_byte;
        bitcnt_nxt = 4'd8;
      end
    end else if (step) begin
      v          = {shift_r[22:0], byte_r[7]};
      byte_nxt   = {byte_r[6:0], 1'b0};
      bitcnt_nxt = bitcnt_r - 4'd1;
      shift_nxt  = v;
      bits_nxt   = bits_r + 13'd1;
      left_nxt   = (left_r != 5'd0) ? left_r - 5'd1 : 5'd0;
      alg_left   = 5'd8 - {2'b00, bits_nxt[2:0]};
      rem        = {1'b0, cfg_i.total_bytes, 3'b000} - {1'b0, bits_nxt};
      rem_ge16   = !rem[13] && (rem[12:0] >= 13'd16);
      rem_ge12   = !rem[13] && (rem[12:0] >= 13'd12);

      if (left_nxt == 5'd0) begin
        case (ph_r)
          PH_AOT, PH_AOT2: begin
            if (v[5:0] == AOT_ESC) begin
              ent = 1'b1; tgt = phase_t'(ph_r + 6'd1);
            end else begin
              ot_nxt = v[5:0];
              recs[n] = mk_rec(FID_AOT, 8'd0, v, bad_nxt); n = n + 3'd1;
              if (ph_r == PH_AOT) begin ent = 1'b1; tgt = PH_SFI; end
              else jmp = J_AFTER_AOT2;
            end
          end
          PH_AOT_ESC, PH_AOT2_ESC: begin
            esc7   = 7'd32 + {1'b0, v[5:0]};
            ot_nxt = esc7[6] ? 6'd63 : esc7[5:0];
            recs[n] = mk_rec(FID_AOT, 8'd0, {17'd0, esc7}, bad_nxt); n = n + 3'd1;
            if (ph_r == PH_AOT_ESC) begin ent = 1'b1; tgt = PH_SFI; end
            else jmp = J_AFTER_AOT2;
          end
          PH_SFI, PH_XSFI, PH_XSFI2: begin
            recs[n] = mk_rec((ph_r == PH_SFI) ? FID_SFI : FID_XSFI, 8'd0, v, bad_nxt);
            n = n + 3'd1;
            ent = 1'b1;
            if (v[3:0] == SFI_ESC) begin
              tgt = phase_t'(ph_r + 6'd1);
            end else begin
              if (v[3:0] == 4'd13 || v[3:0] == 4'd14) bad_nxt = 1'b1;
              recs[n] = mk_rec((ph_r == PH_SFI) ? FID_SF : FID_XSF, 8'd0,
                               freq_of(v[3:0]), bad_nxt);
              n = n + 3'd1;
              case (ph_r)
                PH_SFI:  tgt = PH_CH;
                PH_XSFI: tgt = PH_AOT2;
                default: begin ent = 1'b0; jmp = J_AFTER_XSF2; end
              endcase
            end
          end
          PH_SF_X: begin
            recs[n] = mk_rec(FID_SF, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_CH;
          end
          PH_XSF_X: begin
            recs[n] = mk_rec(FID_XSF, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_AOT2;
          end
          PH_XSF2_X: begin
            recs[n] = mk_rec(FID_XSF, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_AFTER_XSF2;
          end
          PH_CH: begin
            ch_nxt = v[3:0];
            recs[n] = mk_rec(FID_CH, 8'd0, v, bad_nxt); n = n + 3'd1;
            if (ot_r == AOT_SBR || ot_r == AOT_PS) begin
              // implicit SBR/PS signalling
              xot_nxt = AOT_SBR;
              recs[n] = mk_rec(FID_XAOT, 8'd0, 24'd5, bad_nxt); n = n + 3'd1;
              recs[n] = mk_rec(FID_SBR, 8'd0, 24'd1, bad_nxt); n = n + 3'd1;
              recs[n] = mk_rec(FID_PS, 8'd0, {23'd0, ot_r == AOT_PS}, bad_nxt);
              n = n + 3'd1;
              ent = 1'b1; tgt = PH_XSFI;
            end else begin
              xot_nxt = '0;
              jmp = J_DISPATCH;
            end
          end
          PH_XCH_I: begin
            recs[n] = mk_rec(FID_XCH, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_DISPATCH;
          end
          PH_FLF: begin
            recs[n] = mk_rec(FID_FLF, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_DOC;
          end
          PH_DOC: begin
            recs[n] = mk_rec(FID_DOC, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = v[0] ? PH_CCD : PH_EXTF;
          end
          PH_CCD: begin
            recs[n] = mk_rec(FID_CCD, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_EXTF;
          end
          PH_EXTF: begin
            recs[n] = mk_rec(FID_EXTF, 8'd0, v, bad_nxt); n = n + 3'd1;
            ext_nxt = v[0];
            if (ch_r == 4'd0) begin ent = 1'b1; tgt = PH_TAG; end
            else jmp = J_GA_TAIL;
          end
          PH_TAG: begin
            recs[n] = mk_rec(FID_TAG, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_POT;
          end
          PH_POT: begin
            recs[n] = mk_rec(FID_PROFILE, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_PSFI;
          end
          PH_PSFI: begin
            recs[n] = mk_rec(FID_PSFI, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_NF;
          end
          PH_NF, PH_NS, PH_NB, PH_NL, PH_NA, PH_NC: begin
            nt = 3'(ph_r - PH_NF);
            cnt_nxt[nt] = v[3:0];
            recs[n] = mk_rec(FID_NFRONT + {3'd0, nt}, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = phase_t'(ph_r + 6'd1);
          end
          PH_MONO: begin
            recs[n] = mk_rec(FID_MONO, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = v[0] ? PH_MONO_N : PH_STEREO;
          end
          PH_MONO_N: begin
            recs[n] = mk_rec(FID_MONO_N, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_STEREO;
          end
          PH_STEREO: begin
            recs[n] = mk_rec(FID_STEREO, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = v[0] ? PH_STEREO_N : PH_MATRIX;
          end
          PH_STEREO_N: begin
            recs[n] = mk_rec(FID_STEREO_N, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_MATRIX;
          end
          PH_MATRIX: begin
            recs[n] = mk_rec(FID_MATRIX, 8'd0, v, bad_nxt); n = n + 3'd1;
            if (v[0]) begin ent = 1'b1; tgt = PH_MIDX; end
            else jmp = J_LIST;
          end
          PH_MIDX: begin
            recs[n] = mk_rec(FID_MIDX, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_PSEUDO;
          end
          PH_PSEUDO: begin
            recs[n] = mk_rec(FID_PSEUDO, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_LIST;
          end
          PH_F_CPE, PH_S_CPE, PH_B_CPE, PH_C_IND: begin
            case (ph_r)
              PH_F_CPE: recs[n] = mk_rec(FID_F_CPE, ec_r, v, bad_nxt);
              PH_S_CPE: recs[n] = mk_rec(FID_S_CPE, ec_r, v, bad_nxt);
              PH_B_CPE: recs[n] = mk_rec(FID_B_CPE, ec_r, v, bad_nxt);
              default:  recs[n] = mk_rec(FID_C_IND, ec_r, v, bad_nxt);
            endcase
            n = n + 3'd1;
            ent = 1'b1; tgt = phase_t'(ph_r + 6'd1);
          end
          PH_F_TAG, PH_S_TAG, PH_B_TAG, PH_L_TAG, PH_A_TAG, PH_C_TAG: begin
            case (ph_r)
              PH_F_TAG: begin recs[n] = mk_rec(FID_F_TAG, ec_r, v, bad_nxt); nt = 3'd0; end
              PH_S_TAG: begin recs[n] = mk_rec(FID_S_TAG, ec_r, v, bad_nxt); nt = 3'd1; end
              PH_B_TAG: begin recs[n] = mk_rec(FID_B_TAG, ec_r, v, bad_nxt); nt = 3'd2; end
              PH_L_TAG: begin recs[n] = mk_rec(FID_L_TAG, ec_r, v, bad_nxt); nt = 3'd3; end
              PH_A_TAG: begin recs[n] = mk_rec(FID_A_TAG, ec_r, v, bad_nxt); nt = 3'd4; end
              default:  begin recs[n] = mk_rec(FID_C_TAG, ec_r, v, bad_nxt); nt = 3'd5; end
            endcase
            n = n + 3'd1;
            ec_nxt = ec_r + 8'd1;
            if (ec_nxt < {4'd0, cnt_r[nt]}) begin
              ent = 1'b1; tgt = list_first(nt);
            end else begin
              jmp = J_LIST; lk = nt + 3'd1;
            end
          end
          PH_ALIGN: begin
            ent = 1'b1; tgt = PH_CCOUNT;
          end
          PH_CCOUNT: begin
            recs[n] = mk_rec(FID_CCOUNT, 8'd0, v, bad_nxt); n = n + 3'd1;
            // count lives in the first two element counters while bytes run
            cnt_nxt[0] = v[7:4];
            cnt_nxt[1] = v[3:0];
            ec_nxt = '0;
            if (v[7:0] != 8'd0) begin ent = 1'b1; tgt = PH_CBYTE; end
            else jmp = J_GA_TAIL;
          end
          PH_CBYTE: begin
            if (cfg_i.emit_comment_bytes) begin
              recs[n] = mk_rec(FID_CBYTE, ec_r, v, bad_nxt); n = n + 3'd1;
            end
            ec_nxt = ec_r + 8'd1;
            if (ec_nxt >= {cnt_r[0], cnt_r[1]} || ec_nxt == 8'd0) jmp = J_GA_TAIL;
            else begin ent = 1'b1; tgt = PH_CBYTE; end
          end
          PH_LAYER: begin
            recs[n] = mk_rec(FID_LAYER, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_GA_EXT;
          end
          PH_NSF: begin
            recs[n] = mk_rec(FID_NSF, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_LLEN;
          end
          PH_LLEN: begin
            recs[n] = mk_rec(FID_LLEN, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_GA_RES;
          end
          PH_RES1: begin
            recs[n] = mk_rec(FID_RES1, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_RES2;
          end
          PH_RES2: begin
            recs[n] = mk_rec(FID_RES2, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_RES3;
          end
          PH_RES3: begin
            recs[n] = mk_rec(FID_RES3, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_EXT3;
          end
          PH_EXT3: begin
            recs[n] = mk_rec(FID_EXT3, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_EP_CHECK;
          end
          PH_EP: begin
            recs[n] = mk_rec(FID_EP, 8'd0, v, bad_nxt); n = n + 3'd1;
            if (v[1]) begin jmp = J_FINISH; fin_st = ST_UNSUP; end
            else jmp = J_EXT_CHECK;
          end
          PH_SYNC: begin
            recs[n] = mk_rec(FID_SYNC, 8'd0, v, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = (v[10:0] == SYNC_SBR) ? PH_XAOT : PH_SBR;
          end
          PH_XAOT: begin
            ent = 1'b1;
            if (v[5:0] == AOT_ESC) begin
              tgt = PH_XAOT_ESC;
            end else begin
              xot_nxt = v[5:0];
              recs[n] = mk_rec(FID_XAOT, 8'd0, v, bad_nxt); n = n + 3'd1;
              tgt = PH_SBR;
            end
          end
          PH_XAOT_ESC: begin
            esc7    = 7'd32 + {1'b0, v[5:0]};
            xot_nxt = esc7[6] ? 6'd63 : esc7[5:0];
            recs[n] = mk_rec(FID_XAOT, 8'd0, {17'd0, esc7}, bad_nxt); n = n + 3'd1;
            ent = 1'b1; tgt = PH_SBR;
          end
          PH_SBR: begin
            recs[n] = mk_rec(FID_SBR, 8'd0, v, bad_nxt); n = n + 3'd1;
            if (v[0]) begin ent = 1'b1; tgt = PH_XSFI2; end
            else if (xot_r == AOT_SBR) begin jmp = J_FINISH; fin_st = ST_OK; end
            else begin ent = 1'b1; tgt = PH_XCH; end
          end
          PH_SYNC2: begin
            recs[n] = mk_rec(FID_SYNC, 8'd0, v, bad_nxt); n = n + 3'd1;
            if (v[10:0] == SYNC_PS) begin ent = 1'b1; tgt = PH_PS; end
            else jmp = J_FINISH;
          end
          PH_PS: begin
            recs[n] = mk_rec(FID_PS, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_FINISH;
          end
          PH_XCH: begin
            recs[n] = mk_rec(FID_XCH, 8'd0, v, bad_nxt); n = n + 3'd1;
            jmp = J_FINISH;
          end
          default: begin
            ent = 1'b1; tgt = PH_DONE;
          end
        endcase
      end

      // follow-on decisions, in dependency order
      if (jmp == J_AFTER_AOT2) begin
        if (ot_nxt == 6'd22) begin ent = 1'b1; tgt = PH_XCH_I; end
        else jmp = J_DISPATCH;
      end
      if (jmp == J_DISPATCH) begin
        if (is_ga(ot_nxt)) begin ent = 1'b1; tgt = PH_FLF; end
        else if (is_unsup(ot_nxt)) begin jmp = J_FINISH; fin_st = ST_UNSUP; end
        else jmp = J_EP_CHECK;
      end
      if (jmp == J_GA_TAIL) begin
        if (ot_nxt == 6'd6 || ot_nxt == 6'd20) begin ent = 1'b1; tgt = PH_LAYER; end
        else jmp = J_GA_EXT;
      end
      if (jmp == J_GA_EXT) begin
        if (!ext_nxt) jmp = J_EP_CHECK;
        else if (ot_nxt == 6'd22) begin ent = 1'b1; tgt = PH_NSF; end
        else jmp = J_GA_RES;
      end
      if (jmp == J_GA_RES) begin
        ent = 1'b1;
        tgt = (ot_nxt == 6'd17 || ot_nxt == 6'd19 || ot_nxt == 6'd20 || ot_nxt == 6'd23)
              ? PH_RES1 : PH_EXT3;
      end
      if (jmp == J_EP_CHECK) begin
        if (has_ep(ot_nxt)) begin ent = 1'b1; tgt = PH_EP; end
        else jmp = J_EXT_CHECK;
      end
      if (jmp == J_EXT_CHECK) begin
        if (xot_nxt != AOT_SBR && rem_ge16) begin ent = 1'b1; tgt = PH_SYNC; end
        else begin jmp = J_FINISH; fin_st = ST_OK; end
      end
      if (jmp == J_AFTER_XSF2) begin
        if (xot_nxt != AOT_SBR) begin ent = 1'b1; tgt = PH_XCH; end
        else if (rem_ge12) begin ent = 1'b1; tgt = PH_SYNC2; end
        else begin jmp = J_FINISH; fin_st = ST_OK; end
      end
      if (jmp == J_LIST) begin
        for (int k = 0; k < 6; k++) begin
          if (!found && 3'(k) >= lk && cnt_nxt[k] != 4'd0) begin
            found = 1'b1;
            tgt   = list_first(3'(k));
          end
        end
        ent = 1'b1;
        if (found) ec_nxt = '0;
        else if (bits_nxt[2:0] != 3'd0) tgt = PH_ALIGN;
        else tgt = PH_CCOUNT;
      end

      // blob runs out after its last byte while a field is still open
      if (jmp != J_FINISH && bitcnt_r == 4'd1 && (ent ? tgt : ph_r) != PH_DONE &&
          seen_r >= cfg_i.total_bytes) begin
        jmp = J_FINISH; fin_st = ST_TRUNC;
      end
      if (jmp == J_FINISH) begin
        recs[n] = '{field_id: FID_SUMMARY, element_index: 8'd0,
                    field_value: {11'd0, bits_nxt},
                    status: (fin_st == ST_OK && bad_nxt) ? ST_BADFREQ : fin_st,
                    last_result: 1'b1};
        n = n + 3'd1;
        ent = 1'b1; tgt = PH_DONE;
      end

      if (ent) begin
        ph_nxt    = tgt;
        shift_nxt = '0;
        left_nxt  = (tgt == PH_ALIGN) ? alg_left : width_of(tgt);
      end
      if (bitcnt_r == 4'd1 || ph_nxt == PH_DONE) active_nxt = 1'b0;
    end
  end

  assign batch_o = '{push: step, cnt: n, recs: recs};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_AOT;
      shift_r  <= '0;
      left_r   <= width_of(PH_AOT);
      ot_r     <= '0;
      xot_r    <= '0;
      ch_r     <= '0;
      bad_r    <= 1'b0;
      ext_r    <= 1'b0;
      for (int k = 0; k < 6; k++) cnt_r[k] <= '0;
      ec_r     <= '0;
      bits_r   <= '0;
      seen_r   <= '0;
      bitcnt_r <= '0;
      active_r <= 1'b0;
    end else begin
      ph_r     <= ph_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      ot_r     <= ot_nxt;
      xot_r    <= xot_nxt;
      ch_r     <= ch_nxt;
      bad_r    <= bad_nxt;
      ext_r    <= ext_nxt;
      cnt_r    <= cnt_nxt;
      ec_r     <= ec_nxt;
      bits_r   <= bits_nxt;
      seen_r   <= seen_nxt;
      bitcnt_r <= bitcnt_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end
endmodule

FILE: rtl/aac_asc_outq.sv
// ----------------------------------------------------------------------------
// aac_asc_outq
// Holds the records raised by one parsed bit and hands them out one beat
// at a time through a registered output stage.
// ----------------------------------------------------------------------------
module aac_asc_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aac_asc_pkg::batch_t  batch_i,
  output logic                 empty_o,
  aac_asc_out_if.source        out_ch
);
  import aac_asc_pkg::*;

  rec_t [NREC-1:0] recs_r;
  logic [2:0]      cnt_r;
  logic [2:0]      head_r;
  rec_t            out_r;
  logic            vld_r;
  logic            load;

  assign empty_o = (cnt_r == 3'd0);
  assign load    = !empty_o && (!vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      if (batch_i.push && batch_i.cnt != 3'd0) begin
        cnt_r  <= batch_i.cnt;
        head_r <= '0;
      end else if (load) begin
        cnt_r  <= cnt_r - 3'd1;
        head_r <= head_r + 3'd1;
      end
      if (load)              vld_r <= 1'b1;
      else if (out_ch.ready) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_i.push) recs_r <= batch_i.recs;
    if (load)         out_r  <= recs_r[head_r];
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.field_id      = out_r.field_id;
  assign out_ch.element_index = out_r.element_index;
  assign out_ch.field_value   = out_r.field_value;
  assign out_ch.status        = out_r.status;
  assign out_ch.last_result   = out_r.last_result;
endmodule

FILE: tb/aac_audio_specific_config_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// aac_audio_specific_config_parser_unit_tb
// Feeds AudioSpecificConfig blobs into the parser, byte by byte, and checks
// every field record against a bit-serial predictor kept in the bench. Blobs
// are mostly well-formed headers (GA, implicit and explicit SBR/PS, program
// config elements) with random tails, mixed with noise and cut-off blobs.
// ----------------------------------------------------------------------------
module aac_audio_specific_config_parser_unit_tb;
  import aac_asc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  aac_asc_in_if  in_ch ();
  aac_asc_out_if out_ch ();

  aac_audio_specific_config_parser_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------- predictor state ----------------
  localparam int unsigned RATE_HZ [16] = '{
    96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050,
    16000, 12000, 11025, 8000, 7350, 0, 0, 0
  };
  localparam int PHASE_BITS [61] = '{
    5, 6, 4, 24, 4, 4, 24, 5, 6, 4,
    1, 1, 14, 1,
    4, 2, 4, 4, 4, 4, 2, 3, 4, 1, 4, 1, 4, 1, 2, 1,
    1, 4, 1, 4, 1, 4, 4, 4, 1, 4,
    0, 8, 8,
    3, 5, 11, 1, 1, 1, 1,
    2,
    11, 5, 6, 1, 4, 24, 11, 1, 4,
    0
  };

  phase_t      ph;
  logic [23:0] shift_reg;
  int          bits_left;
  int          aot;
  int          ext_aot;
  int          chan_cfg;
  bit          bad_freq;
  bit          ext_flag;
  int          elem_cnt [6];
  int          elem_idx;
  int          nbits;
  int          nbytes;
  int          blob_len;
  bit          keep_comments;

  rec_t fields_due [$];
  int   errors;
  int   cycles;
  bit   long_hold;
  bit   quiet;

  function automatic bit ga_type(int t);
    return (t >= 1 && t <= 4) || t == 6 || t == 7 || (t >= 17 && t <= 23);
  endfunction

  function automatic bit unsup_type(int t);
    return t == 8 || t == 9 || (t >= 12 && t <= 16) || (t >= 24 && t <= 28) ||
           t == 30 || (t >= 32 && t <= 41);
  endfunction

  function automatic bit ep_type(int t);
    return t == 17 || (t >= 19 && t <= 27) || t == 39;
  endfunction

  task automatic put(logic [5:0] id, int idx, int unsigned val);
    rec_t r;
    r.field_id      = id;
    r.element_index = idx[7:0];
    r.field_value   = val[23:0];
    r.status        = bad_freq ? ST_BADFREQ : ST_OK;
    r.last_result   = 1'b0;
    fields_due.push_back(r);
  endtask

  task automatic enter(phase_t p);
    ph        = p;
    bits_left = PHASE_BITS[int'(p)];
    shift_reg = '0;
  endtask

  task automatic close_blob(logic [1:0] st);
    rec_t r;
    if (st == ST_OK && bad_freq) st = ST_BADFREQ;
    r.field_id      = FID_SUMMARY;
    r.element_index = 8'd0;
    r.field_value   = 24'(nbits);
    r.status        = st;
    r.last_result   = 1'b1;
    fields_due.push_back(r);
    enter(PH_DONE);
  endtask

  task automatic put_rate(logic [5:0] id, int idx);
    idx = idx & 15;
    if (idx == 13 || idx == 14) bad_freq = 1'b1;
    put(id, 0, RATE_HZ[idx]);
  endtask

  task automatic ext_check();
    if (ext_aot != 5 && blob_len * 8 - nbits >= 16) enter(PH_SYNC);
    else close_blob(ST_OK);
  endtask

  task automatic ep_check();
    if (ep_type(aot)) enter(PH_EP);
    else ext_check();
  endtask

  task automatic dispatch();
    if (ga_type(aot)) enter(PH_FLF);
    else if (unsup_type(aot)) close_blob(ST_UNSUP);
    else ep_check();
  endtask

  task automatic after_core_aot();
    if (aot == 22) enter(PH_XCH_I);
    else dispatch();
  endtask

  task automatic ga_res();
    if (aot == 17 || aot == 19 || aot == 20 || aot == 23) enter(PH_RES1);
    else enter(PH_EXT3);
  endtask

  task automatic ga_ext();
    if (ext_flag) begin
      if (aot == 22) enter(PH_NSF);
      else ga_res();
    end else begin
      ep_check();
    end
  endtask

  task automatic ga_tail();
    if (aot == 6 || aot == 20) enter(PH_LAYER);
    else ga_ext();
  endtask

  task automatic to_comment();
    int r;
    r = nbits & 7;
    if (r != 0) begin
      enter(PH_ALIGN);
      bits_left = 8 - r;
    end else begin
      enter(PH_CCOUNT);
    end
  endtask

  function automatic phase_t list_head(int k);
    case (k)
      0:       return PH_F_CPE;
      1:       return PH_S_CPE;
      2:       return PH_B_CPE;
      3:       return PH_L_TAG;
      4:       return PH_A_TAG;
      default: return PH_C_IND;
    endcase
  endfunction

  task automatic next_list(int k);
    for (int j = k; j < 6; j++) begin
      if (elem_cnt[j] != 0) begin
        elem_idx = 0;
        enter(list_head(j));
        return;
      end
    end
    to_comment();
  endtask

  task automatic next_elem(int k);
    elem_idx = (elem_idx + 1) & 255;
    if (elem_idx < elem_cnt[k]) enter(list_head(k));
    else next_list(k + 1);
  endtask

  task automatic after_ext_rate();
    if (ext_aot == 5) begin
      if (blob_len * 8 - nbits >= 12) enter(PH_SYNC2);
      else close_blob(ST_OK);
    end else begin
      enter(PH_XCH);
    end
  endtask

  task automatic field_done(int unsigned v);
    int ec;
    int t;
    ec = elem_idx;
    case (ph)
      PH_AOT, PH_AOT2: begin
        if (v == 31) begin
          enter(phase_t'(ph + 1));
        end else begin
          aot = v;
          put(FID_AOT, 0, v);
          if (ph == PH_AOT) enter(PH_SFI);
          else after_core_aot();
        end
      end
      PH_AOT_ESC, PH_AOT2_ESC: begin
        t = 32 + v;
        aot = (t > 63) ? 63 : t;
        put(FID_AOT, 0, t);
        if (ph == PH_AOT_ESC) enter(PH_SFI);
        else after_core_aot();
      end
      PH_SFI: begin
        put(FID_SFI, 0, v);
        if (v == 15) enter(PH_SF_X);
        else begin
          put_rate(FID_SF, v);
          enter(PH_CH);
        end
      end
      PH_SF_X: begin
        put(FID_SF, 0, v);
        enter(PH_CH);
      end
      PH_CH: begin
        chan_cfg = v;
        put(FID_CH, 0, v);
        if (aot == 5 || aot == 29) begin
          ext_aot = 5;
          put(FID_XAOT, 0, 5);
          put(FID_SBR, 0, 1);
          put(FID_PS, 0, (aot == 29) ? 1 : 0);
          enter(PH_XSFI);
        end else begin
          ext_aot = 0;
          dispatch();
        end
      end
      PH_XSFI: begin
        put(FID_XSFI, 0, v);
        if (v == 15) enter(PH_XSF_X);
        else begin
          put_rate(FID_XSF, v);
          enter(PH_AOT2);
        end
      end
      PH_XSF_X: begin
        put(FID_XSF, 0, v);
        enter(PH_AOT2);
      end
      PH_XCH_I: begin
        put(FID_XCH, 0, v);
        dispatch();
      end
      PH_FLF: begin
        put(FID_FLF, 0, v);
        enter(PH_DOC);
      end
      PH_DOC: begin
        put(FID_DOC, 0, v);
        enter(v != 0 ? PH_CCD : PH_EXTF);
      end
      PH_CCD: begin
        put(FID_CCD, 0, v);
        enter(PH_EXTF);
      end
      PH_EXTF: begin
        put(FID_EXTF, 0, v);
        ext_flag = (v != 0);
        if (chan_cfg == 0) enter(PH_TAG);
        else ga_tail();
      end
      PH_TAG: begin
        put(FID_TAG, 0, v);
        enter(PH_POT);
      end
      PH_POT: begin
        put(FID_PROFILE, 0, v);
        enter(PH_PSFI);
      end
      PH_PSFI: begin
        put(FID_PSFI, 0, v);
        enter(PH_NF);
      end
      PH_NF, PH_NS, PH_NB, PH_NL, PH_NA, PH_NC: begin
        t = int'(ph) - int'(PH_NF);
        elem_cnt[t] = v;
        put(FID_NFRONT + 6'(t), 0, v);
        enter(phase_t'(ph + 1));
      end
      PH_MONO: begin
        put(FID_MONO, 0, v);
        enter(v != 0 ? PH_MONO_N : PH_STEREO);
      end
      PH_MONO_N: begin
        put(FID_MONO_N, 0, v);
        enter(PH_STEREO);
      end
      PH_STEREO: begin
        put(FID_STEREO, 0, v);
        enter(v != 0 ? PH_STEREO_N : PH_MATRIX);
      end
      PH_STEREO_N: begin
        put(FID_STEREO_N, 0, v);
        enter(PH_MATRIX);
      end
      PH_MATRIX: begin
        put(FID_MATRIX, 0, v);
        if (v != 0) enter(PH_MIDX);
        else next_list(0);
      end
      PH_MIDX: begin
        put(FID_MIDX, 0, v);
        enter(PH_PSEUDO);
      end
      PH_PSEUDO: begin
        put(FID_PSEUDO, 0, v);
        next_list(0);
      end
      PH_F_CPE: begin
        put(FID_F_CPE, ec, v);
        enter(PH_F_TAG);
      end
      PH_F_TAG: begin
        put(FID_F_TAG, ec, v);
        next_elem(0);
      end
      PH_S_CPE: begin
        put(FID_S_CPE, ec, v);
        enter(PH_S_TAG);
      end
      PH_S_TAG: begin
        put(FID_S_TAG, ec, v);
        next_elem(1);
      end
      PH_B_CPE: begin
        put(FID_B_CPE, ec, v);
        enter(PH_B_TAG);
      end
      PH_B_TAG: begin
        put(FID_B_TAG, ec, v);
        next_elem(2);
      end
      PH_L_TAG: begin
        put(FID_L_TAG, ec, v);
        next_elem(3);
      end
      PH_A_TAG: begin
        put(FID_A_TAG, ec, v);
        next_elem(4);
      end
      PH_C_IND: begin
        put(FID_C_IND, ec, v);
        enter(PH_C_TAG);
      end
      PH_C_TAG: begin
        put(FID_C_TAG, ec, v);
        next_elem(5);
      end
      PH_ALIGN: enter(PH_CCOUNT);
      PH_CCOUNT: begin
        put(FID_CCOUNT, 0, v);
        elem_cnt[0] = (v >> 4) & 15;
        elem_cnt[1] = v & 15;
        elem_idx    = 0;
        if (v != 0) enter(PH_CBYTE);
        else ga_tail();
      end
      PH_CBYTE: begin
        if (keep_comments) put(FID_CBYTE, ec, v);
        elem_idx = (ec + 1) & 255;
        // byte count is parked in the first two list counters as nibbles
        if (elem_idx >= ((elem_cnt[0] << 4) | elem_cnt[1]) || elem_idx == 0) ga_tail();
        else enter(PH_CBYTE);
      end
      PH_LAYER: begin
        put(FID_LAYER, 0, v);
        ga_ext();
      end
      PH_NSF: begin
        put(FID_NSF, 0, v);
        enter(PH_LLEN);
      end
      PH_LLEN: begin
        put(FID_LLEN, 0, v);
        ga_res();
      end
      PH_RES1: begin
        put(FID_RES1, 0, v);
        enter(PH_RES2);
      end
      PH_RES2: begin
        put(FID_RES2, 0, v);
        enter(PH_RES3);
      end
      PH_RES3: begin
        put(FID_RES3, 0, v);
        enter(PH_EXT3);
      end
      PH_EXT3: begin
        put(FID_EXT3, 0, v);
        ep_check();
      end
      PH_EP: begin
        put(FID_EP, 0, v);
        if (v == 2 || v == 3) close_blob(ST_UNSUP);
        else ext_check();
      end
      PH_SYNC: begin
        put(FID_SYNC, 0, v);
        enter(v == SYNC_SBR ? PH_XAOT : PH_SBR);
      end
      PH_XAOT: begin
        if (v == 31) begin
          enter(PH_XAOT_ESC);
        end else begin
          ext_aot = v;
          put(FID_XAOT, 0, v);
          enter(PH_SBR);
        end
      end
      PH_XAOT_ESC: begin
        t = 32 + v;
        ext_aot = (t > 63) ? 63 : t;
        put(FID_XAOT, 0, t);
        enter(PH_SBR);
      end
      PH_SBR: begin
        put(FID_SBR, 0, v);
        if (v != 0) enter(PH_XSFI2);
        else if (ext_aot == 5) close_blob(ST_OK);
        else enter(PH_XCH);
      end
      PH_XSFI2: begin
        put(FID_XSFI, 0, v);
        if (v == 15) enter(PH_XSF2_X);
        else begin
          put_rate(FID_XSF, v);
          after_ext_rate();
        end
      end
      PH_XSF2_X: begin
        put(FID_XSF, 0, v);
        after_ext_rate();
      end
      PH_SYNC2: begin
        put(FID_SYNC, 0, v);
        if (v == SYNC_PS) enter(PH_PS);
        else close_blob(ST_OK);
      end
      PH_PS: begin
        put(FID_PS, 0, v);
        close_blob(ST_OK);
      end
      PH_XCH: begin
        put(FID_XCH, 0, v);
        close_blob(ST_OK);
      end
      default: enter(PH_DONE);
    endcase
  endtask

  task automatic restart_blob();
    enter(PH_AOT);
    aot      = 0;
    ext_aot  = 0;
    chan_cfg = 0;
    bad_freq = 1'b0;
    ext_flag = 1'b0;
    for (int k = 0; k < 6; k++) elem_cnt[k] = 0;
    elem_idx = 0;
    nbits    = 0;
    nbytes   = 0;
  endtask

  task automatic parse_asc_byte(logic [7:0] d, logic fs);
    if (fs) restart_blob();
    if (ph == PH_DONE) return;
    if (nbytes < 1023) nbytes++;
    for (int b = 7; b >= 0 && ph != PH_DONE; b--) begin
      shift_reg = {shift_reg[22:0], d[b]};
      nbits     = (nbits + 1) & 8191;
      if (bits_left > 0) bits_left--;
      if (bits_left == 0) field_done(shift_reg);
    end
    if (ph != PH_DONE && nbytes >= blob_len) close_blob(ST_TRUNC);
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fields_due.size() == 0) begin
        $display("%0t: unexpected record id=%0d idx=%0d val=%0d st=%0d last=%0d", $time,
                 out_ch.field_id, out_ch.element_index, out_ch.field_value,
                 out_ch.status, out_ch.last_result);
        errors++;
      end else begin
        rec_t e;
        e = fields_due.pop_front();
        if (out_ch.field_id !== e.field_id || out_ch.element_index !== e.element_index ||
            out_ch.field_value !== e.field_value || out_ch.status !== e.status ||
            out_ch.last_result !== e.last_result) begin
          $display("%0t: mismatch expected id=%0d idx=%0d val=%0d st=%0d last=%0d", $time,
                   e.field_id, e.element_index, e.field_value, e.status, e.last_result);
          $display("%0t:           actual id=%0d idx=%0d val=%0d st=%0d last=%0d", $time,
                   out_ch.field_id, out_ch.element_index, out_ch.field_value,
                   out_ch.status, out_ch.last_result);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("aac_audio_specific_config_parser_unit test failed");
      $finish;
    end
  end

  // receiver: random back-pressure bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_beat(logic [7:0] d, logic fs, output int first_new);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    first_new = fields_due.size();
    parse_asc_byte(d, fs);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'(4 * REG_TOTAL)) blob_len = val[9:0];
    else keep_comments = val[0];
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    // the parser may still be chewing on bits that raise nothing
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  bit hdr_bits [$];

  task automatic push_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) hdr_bits.push_back(v[i]);
  endtask

  // well-formed header start, then random content up to nb bytes
  task automatic build_blob(int nb, output logic [7:0] bytes_out [$]);
    int t;
    int ch;
    int picks [14] = '{1, 2, 2, 2, 5, 29, 17, 19, 20, 22, 6, 23, 31, 39};
    hdr_bits.delete();
    bytes_out.delete();
    t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : picks[$urandom_range(0, 13)];
    push_bits(t, 5);
    if (t == 31) push_bits($urandom_range(0, 63), 6);
    if ($urandom_range(0, 7) == 0) begin
      push_bits(15, 4);
      push_bits($urandom(), 24);
    end else begin
      push_bits($urandom_range(0, 14), 4);
    end
    ch = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
    push_bits(ch, 4);
    if (t == 5 || t == 29) begin
      push_bits($urandom_range(0, 12), 4);
      push_bits(2, 5);
    end else if (t == 2 && ch != 0 && $urandom_range(0, 1) == 0) begin
      // plain GA then explicit SBR/PS signalling
      push_bits(0, 3);
      push_bits(SYNC_SBR, 11);
      push_bits(5, 5);
      push_bits(1, 1);
      push_bits($urandom_range(0, 12), 4);
      push_bits(SYNC_PS, 11);
      push_bits($urandom_range(0, 1), 1);
    end
    while (hdr_bits.size() < nb * 8) hdr_bits.push_back($urandom_range(0, 1));
    for (int i = 0; i < nb; i++) begin
      logic [7:0] b;
      for (int j = 0; j < 8; j++) b[7 - j] = hdr_bits[i * 8 + j];
      bytes_out.push_back(b);
    end
  endtask

  typedef struct {
    logic [7:0] d;
    logic       fs;
    logic       typed;
    rec_t       first;
  } dir_row_t;

  localparam int NDIR = 21;
  dir_row_t dir_rows [NDIR] = '{
    '{8'h10, 1'b1, 1'b1, '{FID_AOT, 8'd0, 24'd2, ST_OK, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{FID_SFI, 8'd0, 24'd0, ST_OK, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h16, 1'b1, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1, '{FID_SFI, 8'd0, 24'd13, ST_OK, 1'b0}},
    '{8'hF8, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h28, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hE8, 1'b1, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h10, 1'b1, 1'b0, '0},
    '{8'h10, 1'b1, 1'b0, '0},
    '{8'h7C, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{FID_AOT, 8'd0, 24'd0, ST_OK, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h78, 1'b1, 1'b0, '0},
    '{8'h08, 1'b1, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b0, '0}
  };

  localparam int NPHASE = 5;
  int phase_len  [NPHASE] = '{1, 1023, 9, 24, 16};
  int phase_emit [NPHASE] = '{1, 0, 1, 0, 1};

  initial begin
    logic [7:0] blob [$];
    int first_new;
    int sent;
    int nb;
    errors      = 0;
    cycles      = 0;
    long_hold   = 1'b0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte   = 8'd0;
    in_ch.frame_start = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = 3'd0;
    pwdata  = 32'd0;
    blob_len      = 2;
    keep_comments = 1'b1;
    restart_blob();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run with the reset settings
    for (int i = 0; i < NDIR; i++) begin
      send_beat(dir_rows[i].d, dir_rows[i].fs, first_new);
      if (dir_rows[i].typed && fields_due.size() > first_new)
        fields_due[first_new] = dir_rows[i].first;
    end

    for (int p = 0; p < NPHASE; p++) begin
      wait_drained();
      cfg_write(3'(4 * REG_TOTAL), 32'(phase_len[p]));
      cfg_write(3'(4 * REG_EMIT), 32'(phase_emit[p]));
      quiet = (p == NPHASE - 1);
      if (p == 2) long_hold = 1'b1;
      sent = 0;
      while (sent < 54) begin
        nb = $urandom_range(2, 18);
        if ($urandom_range(0, 7) == 0) begin
          // noise: random bytes with stray frame starts
          for (int i = 0; i < nb; i++)
            send_beat($urandom_range(0, 255), $urandom_range(0, 9) == 0, first_new);
        end else begin
          build_blob(nb, blob);
          // sometimes cut the blob short; the next start drops it
          if ($urandom_range(0, 5) == 0) nb = $urandom_range(1, nb);
          for (int i = 0; i < nb; i++) send_beat(blob[i], i == 0, first_new);
        end
        sent += nb;
      end
    end

    in_ch.valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("aac_audio_specific_config_parser_unit test passed");
    end else begin
      $display("aac_audio_specific_config_parser_unit test failed");
    end
    $finish;
  end

endmodule
